@@ hw/rtl/ydp_pkg.sv @@
// Shared types, sizes, register indexes and color conversion tables for the
// YUV to RGB DIB packer. No dependencies; every other file imports this one.
`default_nettype none

package ydp_pkg;

  // Frame size limits and the counter widths derived from them.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int COLOFF_W   = COL_W + 2;

  // Field and register widths.
  localparam int SAMPLE_W    = 8;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = 26;
  localparam int BCOUNT_W    = 3;
  localparam int FMT_W       = 2;
  localparam int SIZE_W      = 13;
  localparam int STRIDE_W    = 15;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_INDEX_W = 3;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_UP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE   = 3'd4;

  // Pixel format codes and their byte counts.
  localparam logic [FMT_W-1:0] FMT_555    = 2'd0;
  localparam logic [FMT_W-1:0] FMT_BGR24  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_BGRX32 = 2'd2;

  localparam logic [BCOUNT_W-1:0] BYTES_555    = 3'd2;
  localparam logic [BCOUNT_W-1:0] BYTES_BGR24  = 3'd3;
  localparam logic [BCOUNT_W-1:0] BYTES_BGRX32 = 3'd4;

  // Register values after reset.
  localparam logic [FMT_W-1:0]    RST_PIXEL_FORMAT = FMT_BGR24;
  localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH  = 13'd320;
  localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT = 13'd240;
  localparam logic                RST_BOTTOM_UP    = 1'b1;
  localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE   = 15'd960;

  // Queue depths.
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [FMT_W-1:0]    pixel_format;
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
    logic                bottom_up;
    logic [STRIDE_W-1:0] row_stride;
  } cfg_t;

  // Request passed from the addressing front to the color back end.
  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] chroma_blue;
    logic [SAMPLE_W-1:0] chroma_red;
    logic [ADDR_W-1:0]   byte_address;
    logic [BCOUNT_W-1:0] byte_count;
    logic                frame_end;
  } mid_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   pixel_word;
    logic [ADDR_W-1:0]   byte_address;
    logic [BCOUNT_W-1:0] byte_count;
    logic                frame_end;
  } out_item_t;

  // 16.16 fixed-point conversion terms, one table entry per sample code.
  localparam int  TERM_W     = 26;
  localparam int  SUM_W      = 27;
  localparam int  TAB_DEPTH  = 1 << SAMPLE_W;
  localparam longint FIX_DIV = 1000;
  localparam longint COEF_Y  = 76283904;
  localparam longint COEF_RV = 104595456;
  localparam longint COEF_GU = -25624576;
  localparam longint COEF_GV = -53280768;
  localparam longint COEF_BU = 132251648;
  localparam longint HALF_UP = 500;
  localparam longint HALF_DN = -500;
  localparam longint LUMA_OFS   = 16;
  localparam longint CHROMA_OFS = 128;

  typedef logic signed [TERM_W-1:0] term_t;
  typedef term_t term_tab_t [TAB_DEPTH];

  // Division truncates toward zero, which matches the rounding of the scheme.
  function automatic term_tab_t build_tab(longint ofs, longint coef, longint half);
    term_tab_t tab;
    longint    n;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      n      = longint'(i) - ofs;
      tab[i] = term_t'((n * coef + half) / FIX_DIV);
    end
    return tab;
  endfunction

  localparam term_tab_t Y_TAB  = build_tab(LUMA_OFS, COEF_Y, HALF_UP);
  localparam term_tab_t RV_TAB = build_tab(CHROMA_OFS, COEF_RV, HALF_UP);
  localparam term_tab_t GU_TAB = build_tab(CHROMA_OFS, COEF_GU, HALF_DN);
  localparam term_tab_t GV_TAB = build_tab(CHROMA_OFS, COEF_GV, HALF_DN);
  localparam term_tab_t BU_TAB = build_tab(CHROMA_OFS, COEF_BU, HALF_UP);

endpackage

`default_nettype wire

@@ hw/rtl/yuv_to_rgb_dib_packer_unit.sv @@
// A pixel passes the input register, the request queue, the lookup register and the
// result queue to the result ports. Throughput: one pixel per clock while full is low,
// as no lookup or multiply stalls; both queues keep up while the consumer pops each cycle.
// Reset (rst, synchronous, active high): registers return to their defaults, the
// counters clear and both queues empty; no clearing pass is needed.
// Top level: configuration registers, front end, request queue and back end. Depends on ydp_pkg.
`default_nettype none

module yuv_to_rgb_dib_packer_unit
  import ydp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SAMPLE_W-1:0]    luma,
  input  wire logic [SAMPLE_W-1:0]    chroma_blue,
  input  wire logic [SAMPLE_W-1:0]    chroma_red,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [WORD_W-1:0]           pixel_word,
  output logic [ADDR_W-1:0]           byte_address,
  output logic [BCOUNT_W-1:0]         byte_count,
  output logic                        frame_end
);

  cfg_t                 cfg;
  logic                 mid_write;
  mid_item_t            mid_item;
  logic                 mid_read;
  mid_item_t            mid_head;
  logic [MID_CNT_W-1:0] mid_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= RST_PIXEL_FORMAT;
      cfg.frame_width  <= RST_FRAME_WIDTH;
      cfg.frame_height <= RST_FRAME_HEIGHT;
      cfg.bottom_up    <= RST_BOTTOM_UP;
      cfg.row_stride   <= RST_ROW_STRIDE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[FMT_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[SIZE_W-1:0];
        REG_BOTTOM_UP:    cfg.bottom_up    <= cfg_data[0];
        REG_ROW_STRIDE:   cfg.row_stride   <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  ydp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .luma        (luma),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .mid_count   (mid_count),
    .mid_write   (mid_write),
    .mid_item    (mid_item)
  );

  ydp_mid_queue u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_write),
    .wr_item (mid_item),
    .rd_en   (mid_read),
    .head    (mid_head),
    .count   (mid_count)
  );

  ydp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pixel_format (cfg.pixel_format),
    .mid_head     (mid_head),
    .mid_count    (mid_count),
    .mid_read     (mid_read),
    .empty        (empty),
    .pop          (pop),
    .pixel_word   (pixel_word),
    .byte_address (byte_address),
    .byte_count   (byte_count),
    .frame_end    (frame_end)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ydp_front.sv @@
// Front end: accepts pixels, keeps the column and row counters and forms the
// output byte address. Depends on ydp_pkg.
`default_nettype none

module ydp_front
  import ydp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [SAMPLE_W-1:0]  luma,
  input  wire logic [SAMPLE_W-1:0]  chroma_blue,
  input  wire logic [SAMPLE_W-1:0]  chroma_red,
  input  wire logic [MID_CNT_W-1:0] mid_count,
  output logic                      mid_write,
  output mid_item_t                 mid_item
);

  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [COL_W-1:0]    width_m1;
  logic [ROW_W-1:0]    height_m1;
  logic                last_col;
  logic                last_row;
  logic                accept;
  logic [BCOUNT_W-1:0] bytes;
  logic [COLOFF_W-1:0] col_off;
  logic [ROW_W-1:0]    dst_row;

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_luma;
  logic [SAMPLE_W-1:0] s1_cb;
  logic [SAMPLE_W-1:0] s1_cr;
  logic [ROW_W-1:0]    s1_dst_row;
  logic [COLOFF_W-1:0] s1_col_off;
  logic [BCOUNT_W-1:0] s1_bytes;
  logic                s1_end;

  logic [ROW_W+STRIDE_W-1:0] row_base;
  logic [ROW_W+STRIDE_W:0]   addr_sum;

  // Sizes outside 1..max count as the nearest limit.
  always_comb begin
    priority if (cfg.frame_width == '0) begin
      width_m1 = '0;
    end else if ({1'b0, cfg.frame_width} > (SIZE_W+1)'(MAX_WIDTH)) begin
      width_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_m1 = COL_W'(cfg.frame_width - 1'b1);
    end
    priority if (cfg.frame_height == '0) begin
      height_m1 = '0;
    end else if ({1'b0, cfg.frame_height} > (SIZE_W+1)'(MAX_HEIGHT)) begin
      height_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_m1 = ROW_W'(cfg.frame_height - 1'b1);
    end
  end

  // A counter left beyond the end by a size change counts as the last position.
  assign last_col = column_count >= width_m1;
  assign last_row = row_count >= height_m1;

  always_comb begin
    unique case (cfg.pixel_format)
      FMT_BGRX32: begin
        bytes   = BYTES_BGRX32;
        col_off = {column_count, 2'b00};
      end
      FMT_BGR24: begin
        bytes   = BYTES_BGR24;
        col_off = {column_count, 1'b0} + {2'b00, column_count};
      end
      default: begin
        bytes   = BYTES_555;
        col_off = {1'b0, column_count, 1'b0};
      end
    endcase
  end

  always_comb begin
    if (!cfg.bottom_up) begin
      dst_row = row_count;
    end else if (last_row) begin
      dst_row = '0;
    end else begin
      dst_row = height_m1 - row_count;
    end
  end

  // In-flight stage plus queued requests must leave room for one more.
  assign full   = ({1'b0, mid_count} + (MID_CNT_W+1)'(s1_valid)) >= (MID_CNT_W+1)'(MID_DEPTH);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_luma    <= luma;
      s1_cb      <= chroma_blue;
      s1_cr      <= chroma_red;
      s1_dst_row <= dst_row;
      s1_col_off <= col_off;
      s1_bytes   <= bytes;
      s1_end     <= last_col && last_row;
    end
  end

  assign row_base = s1_dst_row * cfg.row_stride;
  assign addr_sum = (ROW_W+STRIDE_W+1)'(row_base) + (ROW_W+STRIDE_W+1)'(s1_col_off);

  assign mid_write             = s1_valid;
  assign mid_item.luma         = s1_luma;
  assign mid_item.chroma_blue  = s1_cb;
  assign mid_item.chroma_red   = s1_cr;
  assign mid_item.byte_address = addr_sum[ADDR_W-1:0];
  assign mid_item.byte_count   = s1_bytes;
  assign mid_item.frame_end    = s1_end;

endmodule

`default_nettype wire

@@ hw/rtl/ydp_mid_queue.sv @@
// Short request queue between the addressing front and the color back end.
// Depends on ydp_pkg.
`default_nettype none

module ydp_mid_queue
  import ydp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire mid_item_t            wr_item,
  input  wire logic                 rd_en,
  output mid_item_t                 head,
  output logic [MID_CNT_W-1:0]      count
);

  mid_item_t            entries [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr;
  logic [MID_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  assign head = entries[rd_ptr];

endmodule

`default_nettype wire

@@ hw/rtl/ydp_back.sv @@
// Back end: table lookup of the fixed-point terms, sum, floor, clamp and
// packing, followed by the result queue. Depends on ydp_pkg.
`default_nettype none

module ydp_back
  import ydp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [FMT_W-1:0]     pixel_format,
  input  wire mid_item_t            mid_head,
  input  wire logic [MID_CNT_W-1:0] mid_count,
  output logic                      mid_read,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [WORD_W-1:0]         pixel_word,
  output logic [ADDR_W-1:0]         byte_address,
  output logic [BCOUNT_W-1:0]       byte_count,
  output logic                      frame_end
);

  logic                b1_valid;
  term_t               t_y;
  term_t               t_rv;
  term_t               t_gu;
  term_t               t_gv;
  term_t               t_bu;
  logic [ADDR_W-1:0]   b1_addr;
  logic [BCOUNT_W-1:0] b1_bytes;
  logic                b1_end;

  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_b;
  logic [7:0]              red;
  logic [7:0]              green;
  logic [7:0]              blue;
  out_item_t               result;

  out_item_t            oq [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] oq_wr_ptr;
  logic [OUT_PTR_W-1:0] oq_rd_ptr;
  logic [OUT_CNT_W-1:0] oq_count;
  logic                 oq_pop;

  // Arithmetic shift by 16 is the floor of the 16.16 value.
  function automatic logic [7:0] clamp_pixel(logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-17:0] q;
    q = (SUM_W-16)'(s >>> 16);
    if (q < 0) begin
      return 8'd0;
    end else if (q > 255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  // The lookup stage only takes a request when the result queue has room
  // for it and for the one already in flight.
  assign mid_read = (mid_count != '0) &&
                    (({1'b0, oq_count} + (OUT_CNT_W+1)'(b1_valid)) < (OUT_CNT_W+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= mid_read;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_read) begin
      t_y      <= Y_TAB[mid_head.luma];
      t_rv     <= RV_TAB[mid_head.chroma_red];
      t_gu     <= GU_TAB[mid_head.chroma_blue];
      t_gv     <= GV_TAB[mid_head.chroma_red];
      t_bu     <= BU_TAB[mid_head.chroma_blue];
      b1_addr  <= mid_head.byte_address;
      b1_bytes <= mid_head.byte_count;
      b1_end   <= mid_head.frame_end;
    end
  end

  assign sum_r = SUM_W'(t_y) + SUM_W'(t_rv);
  assign sum_g = SUM_W'(t_y) + SUM_W'(t_gu) + SUM_W'(t_gv);
  assign sum_b = SUM_W'(t_y) + SUM_W'(t_bu);
  assign red   = clamp_pixel(sum_r);
  assign green = clamp_pixel(sum_g);
  assign blue  = clamp_pixel(sum_b);

  always_comb begin
    unique case (pixel_format)
      FMT_BGRX32, FMT_BGR24: begin
        result.pixel_word = {8'd0, red, green, blue};
      end
      default: begin
        result.pixel_word = {17'd0, red[7:3], green[7:3], blue[7:3]};
      end
    endcase
    result.byte_address = b1_addr;
    result.byte_count   = b1_bytes;
    result.frame_end    = b1_end;
  end

  assign empty  = (oq_count == '0);
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr_ptr <= '0;
      oq_rd_ptr <= '0;
      oq_count  <= '0;
    end else begin
      if (b1_valid) begin
        oq_wr_ptr <= oq_wr_ptr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_ptr <= oq_rd_ptr + 1'b1;
      end
      unique case ({b1_valid, oq_pop})
        2'b10:   oq_count <= oq_count + 1'b1;
        2'b01:   oq_count <= oq_count - 1'b1;
        default: oq_count <= oq_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      oq[oq_wr_ptr] <= result;
    end
  end

  assign pixel_word   = oq[oq_rd_ptr].pixel_word;
  assign byte_address = oq[oq_rd_ptr].byte_address;
  assign byte_count   = oq[oq_rd_ptr].byte_count;
  assign frame_end    = oq[oq_rd_ptr].frame_end;

endmodule

`default_nettype wire

@@ hw/rtl/ydp_checker.sv @@
// Port-level checker for the packer top level, attached by the bind below.
// Depends on ydp_pkg.
`default_nettype none

module ydp_checker
  import ydp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   push,
  input wire logic                   full,
  input wire logic                   empty,
  input wire logic                   pop,
  input wire logic [WORD_W-1:0]      pixel_word,
  input wire logic [ADDR_W-1:0]      byte_address,
  input wire logic [BCOUNT_W-1:0]    byte_count
);

  localparam int CAPACITY = MID_DEPTH + OUT_DEPTH + 2;
  localparam int PEND_W   = $clog2(CAPACITY + 1) + 1;

  logic [PEND_W-1:0] pending;
  logic              in_take;
  logic              out_take;

  assign in_take  = push && !full;
  assign out_take = pop && !empty;

  // Requests accepted whose results have not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_W'(in_take) - PEND_W'(out_take);
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pending != '0)
    else $error("result shown with no request outstanding");

  a_bounded_pending: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(CAPACITY))
    else $error("more requests outstanding than the block can hold");

  a_byte_count_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (byte_count == BYTES_555 || byte_count == BYTES_BGR24 ||
                byte_count == BYTES_BGRX32))
    else $error("illegal byte count on result");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_word) && $stable(byte_address)))
    else $error("waiting result changed before it was taken");

endmodule

bind yuv_to_rgb_dib_packer_unit ydp_checker u_ydp_checker (.*);

`default_nettype wire
